// File: hdl/lsbe_pkg.sv
// Shared types and constants of the LSB message embedder.
// Used by the front classifier, the item queue, the embed engine and the top level.
package lsbe_pkg;

    // Input item kinds carried on the slave tuser
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_LAST  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;

    // Widest channel field and the per-channel limit
    localparam logic [3:0] MAX_BITS = 4'd8;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic       is_pixel;
        logic       is_last;
        logic [7:0] data_byte;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

    // Finished pixel result
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] bits_used;
        logic       message_done;
        logic       overflow_seen;
    } t_pixel_out;

endpackage

// File: hdl/lsbe_front.sv
// Front end: accepts stream transactions and classifies them into queue items.
// Depends on lsbe_pkg for the mode codes and the item type.
module lsbe_front
    import lsbe_pkg::*;
(
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic w_known;

    // Accept whenever the queue has room; unused mode codes are dropped
    assign o_s_tready = !i_q_full;

    always_comb begin
        unique case (i_s_tuser)
            MODE_BYTE, MODE_LAST, MODE_PIXEL: w_known = 1'b1;
            default:                          w_known = 1'b0;
        endcase
    end

    assign o_push = i_s_tvalid && !i_q_full && w_known;

    // Unpack the payload and tag the item kind
    always_comb begin
        o_item.is_pixel  = (i_s_tuser == MODE_PIXEL);
        o_item.is_last   = (i_s_tuser == MODE_LAST);
        o_item.data_byte = i_s_tdata[7:0];
        o_item.red       = i_s_tdata[15:8];
        o_item.green     = i_s_tdata[23:16];
        o_item.blue      = i_s_tdata[31:24];
    end

endmodule

// File: hdl/lsbe_fifo.sv
// Short item queue between the front classifier and the embed engine.
// Depends on lsbe_pkg for the item type and the depth.
module lsbe_fifo
    import lsbe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_item           r_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Store the payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/lsbe_embed.sv
// Back end: holds the message bit queue and embeds bits into pixel channels.
// Depends on lsbe_pkg for the item and result types.
module lsbe_embed
    import lsbe_pkg::*;
#(
    parameter int QUEUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_pixel_out o_out
);

    localparam int CW = $clog2(QUEUE_BITS + 1);

    logic [QUEUE_BITS-1:0] r_q;
    logic [CW-1:0]         r_cnt;
    logic                  r_fin;
    logic                  r_ovf;
    logic [3:0]            r_bpc;
    logic                  r_out_valid;
    t_pixel_out            r_out;

    logic [3:0]            w_n;
    logic [7:0]            w_keep;
    logic [QUEUE_BITS-1:0] q_s [0:3];
    logic [CW-1:0]         c_s [0:3];
    logic [3:0]            take [0:2];
    logic [7:0]            ch_in [0:2];
    logic [7:0]            ch_out [0:2];
    logic [4:0]            w_used;
    logic                  w_room;
    logic                  n_fin;
    logic [QUEUE_BITS-1:0] n_q;
    logic [CW-1:0]         n_cnt;

    // Clamp the register to 1..8
    always_comb begin
        priority if (r_bpc == 4'd0) begin
            w_n = 4'd1;
        end else if (r_bpc > MAX_BITS) begin
            w_n = MAX_BITS;
        end else begin
            w_n = r_bpc;
        end
    end

    // Upper bits kept in each channel
    assign w_keep = ~(8'hFF >> (MAX_BITS - w_n));

    assign ch_in[0] = i_item.red;
    assign ch_in[1] = i_item.green;
    assign ch_in[2] = i_item.blue;

    // Draw bits for red, green and blue in turn
    always_comb begin
        logic [7:0] v;
        logic [3:0] pos;
        q_s[0] = r_q;
        c_s[0] = r_cnt;
        for (int k = 0; k < 3; k++) begin
            priority if (c_s[k] == '0) begin
                take[k] = 4'd0;
            end else if (c_s[k] >= CW'(w_n)) begin
                take[k] = w_n;
            end else if (r_fin) begin
                take[k] = c_s[k][3:0];
            end else begin
                take[k] = 4'd0;
            end
            v = 8'd0;
            for (int j = 0; j < 8; j++) begin
                pos = w_n - 4'd1 - 4'(j);
                if (4'(j) < w_n && pos < take[k]) begin
                    v[j] = q_s[k][pos[2:0]];
                end
            end
            ch_out[k] = (take[k] == 4'd0) ? ch_in[k] : ((ch_in[k] & w_keep) | v);
            q_s[k+1]  = q_s[k] >> take[k];
            c_s[k+1]  = c_s[k] - CW'(take[k]);
        end
    end

    assign w_used = 5'(take[0]) + 5'(take[1]) + 5'(take[2]);

    // Byte append: room check and insertion above the queued bits
    assign w_room = ({1'b0, r_cnt} + (CW+1)'(8)) <= (CW+1)'(QUEUE_BITS);
    assign n_q    = r_q | (QUEUE_BITS'(i_item.data_byte) << r_cnt);
    assign n_cnt  = r_cnt + CW'(8);
    assign n_fin  = r_fin && (r_cnt != '0);

    // Take the head unless a pixel would overwrite a waiting result
    assign o_pop = i_valid && (!i_item.is_pixel || !r_out_valid || i_out_ready);

    // Control and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= '0;
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_ovf       <= 1'b0;
            r_bpc       <= 4'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bpc <= i_cfg_wr_data;
            end
            // Load a new result or drop the one the receiver took
            if (o_pop && i_item.is_pixel) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.is_pixel) begin
                    r_q   <= q_s[3];
                    r_cnt <= c_s[3];
                end else begin
                    if (w_room) begin
                        r_q   <= n_q;
                        r_cnt <= n_cnt;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_fin <= i_item.is_last ? 1'b1 : n_fin;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.is_pixel) begin
            r_out.red           <= ch_out[0];
            r_out.green         <= ch_out[1];
            r_out.blue          <= ch_out[2];
            r_out.bits_used     <= w_used;
            r_out.message_done  <= r_fin && (c_s[3] == '0);
            r_out.overflow_seen <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Queue never holds more than its capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_BITS))
        else $error("bit queue count beyond capacity");

    // Bits above the queued count stay clear
    a_q_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q >> r_cnt) == '0)
        else $error("stale bits above queue count");

    // Overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    // A stalled result is never overwritten by a pixel
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_pop && i_item.is_pixel))
        else $error("pixel popped over a stalled result");

endmodule

// File: hdl/lsb_message_embedder.sv
// LSB message embedder, top level: front classifier, item queue, embed engine.
// An accepted pixel is written into the item queue, then embedded and registered as the result.
// Throughput: one transaction and one embedded item per cycle unless a result is stalled.
// Byte transactions and unused mode codes give no result transaction.
// Reset (i_rst_n low, synchronous) empties the queues, clears the flags and
// sets bits_per_channel to 1.
module lsb_message_embedder
    import lsbe_pkg::*;
#(
    parameter int QUEUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,   // bits_per_channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,       // data_byte[7:0], red_in, green_in, blue_in
    input  logic [1:0]  i_s_tuser,       // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,       // red_out, green_out, blue_out, bits_used[4:0], zeros
    output logic [1:0]  o_m_tuser        // message_done, overflow_seen
);

    logic       w_push;
    t_item      w_in_item;
    logic       w_full;
    logic       w_pop;
    logic       w_head_valid;
    t_item      w_head;
    t_pixel_out w_res;

    lsbe_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_item     (w_in_item)
    );

    lsbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head)
    );

    lsbe_embed #(
        .QUEUE_BITS (QUEUE_BITS)
    ) u_embed (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (w_head_valid),
        .i_item        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out         (w_res)
    );

    // Pack the result
    assign o_m_tdata = {3'b000, w_res.bits_used, w_res.blue, w_res.green, w_res.red};
    assign o_m_tuser = {w_res.overflow_seen, w_res.message_done};

endmodule
